FILE: hw/rtl/bsf_pkg.sv
// Shared types and constants for the IPv4 source blocklist filter.
package bsf_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_SET   = 2'd1,
    OP_DEL   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_ACK     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_SET    = 2'd1,
    CMD_DEL    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic        hdr_done;
    logic [31:0] key;
    logic        drop;
  } cmd_t;

endpackage

FILE: hw/rtl/bsf_front.sv
// Frame parser and command builder.
module bsf_front import bsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] key_address_i,
  input  logic [31:0] entry_value_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  localparam logic [2:0] PH_ETH  = 3'd0;
  localparam logic [2:0] PH_TAG  = 3'd1;
  localparam logic [2:0] PH_IPV4 = 3'd2;
  localparam logic [2:0] PH_DONE = 3'd3;
  localparam logic [2:0] PH_PASS = 3'd4;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_QINQ = 16'h88A8;

  logic [5:0]  off_q, off_d, hs_q, hs_d, rel;
  logic [15:0] et_q, et_d;
  logic [1:0]  tags_q, tags_d;
  logic [2:0]  ph_q, ph_d;
  logic [31:0] sa_q, sa_d;
  logic        disp, may_tag;
  logic [5:0]  nstart;
  op_e         op;

  assign op  = op_e'(op_i);
  assign rel = off_q - hs_q;

  always_comb begin
    off_d   = (off_q < 6'd63) ? off_q + 6'd1 : off_q;
    hs_d    = hs_q;
    et_d    = et_q;
    tags_d  = tags_q;
    ph_d    = ph_q;
    sa_d    = sa_q;
    disp    = 1'b0;
    may_tag = 1'b0;
    nstart  = 6'd14;
    unique case (ph_q)
      PH_ETH: begin
        if (off_q == 6'd12) begin
          et_d = {data_byte_i, 8'h00};
        end else if (off_q == 6'd13) begin
          et_d    = {et_q[15:8], data_byte_i};
          disp    = 1'b1;
          may_tag = 1'b1;
        end
      end
      PH_TAG: begin
        if (rel == 6'd2) begin
          et_d = {data_byte_i, 8'h00};
        end else if (rel == 6'd3) begin
          et_d    = {et_q[15:8], data_byte_i};
          tags_d  = tags_q + 2'd1;
          disp    = 1'b1;
          may_tag = (tags_d < 2'd2);
          nstart  = off_q + 6'd1;
        end
      end
      PH_IPV4: begin
        if (rel >= 6'd12 && rel <= 6'd15) sa_d = {sa_q[23:0], data_byte_i};
        if (rel == 6'd19) ph_d = PH_DONE;
      end
      default: ;
    endcase
    if (disp) begin
      if (may_tag && (et_d == TYPE_VLAN || et_d == TYPE_QINQ)) begin
        ph_d = PH_TAG;
        hs_d = nstart;
      end else if (et_d == TYPE_IPV4) begin
        ph_d = PH_IPV4;
        hs_d = nstart;
      end else begin
        ph_d = PH_PASS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      hs_q   <= '0;
      et_q   <= '0;
      tags_q <= '0;
      ph_q   <= PH_ETH;
      sa_q   <= '0;
    end else if (accept_i && op == OP_FRAME) begin
      if (last_byte_i) begin
        off_q  <= '0;
        hs_q   <= '0;
        et_q   <= '0;
        tags_q <= '0;
        ph_q   <= PH_ETH;
        sa_q   <= '0;
      end else begin
        off_q  <= off_d;
        hs_q   <= hs_d;
        et_q   <= et_d;
        tags_q <= tags_d;
        ph_q   <= ph_d;
        sa_q   <= sa_d;
      end
    end
  end

  always_comb begin
    push_o       = 1'b0;
    cmd_o.cmd      = CMD_LOOKUP;
    cmd_o.hdr_done = (ph_d == PH_DONE);
    cmd_o.key      = sa_d;
    cmd_o.drop     = (entry_value_i != 32'd0);
    case (op)
      OP_FRAME: push_o = accept_i && last_byte_i;
      OP_SET: begin
        push_o    = accept_i;
        cmd_o.cmd = CMD_SET;
        cmd_o.key = key_address_i;
      end
      OP_DEL: begin
        push_o    = accept_i;
        cmd_o.cmd = CMD_DEL;
        cmd_o.key = key_address_i;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/bsf_queue.sv
// Two-entry command queue between parser and table engine.
module bsf_queue import bsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: hw/rtl/bsf_back.sv
// Table engine: linear scan of the key memory, then update and respond.
module bsf_back import bsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic avail_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic       verdict_o,
  output logic [1:0] status_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]       state_q;
  cmd_t             cmd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q, hit_idx_q, free_idx_q, widx;
  logic             hit_q, free_q;
  logic [31:0]      rdata_q;
  logic [31:0]      keys [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, drop_q;
  logic             out_valid_q, kind_q, verdict_q, out_free, wr_key;
  logic [1:0]       status_q;

  assign pop_o       = (state_q == S_IDLE) && avail_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign verdict_o   = verdict_q;
  assign status_o    = status_q;
  assign widx        = hit_q ? hit_idx_q : free_idx_q;
  assign wr_key      = (state_q == S_RESP) && out_free && cmd_q.cmd == CMD_SET && !hit_q && free_q;

  always_ff @(posedge clk_i) begin
    if (wr_key) keys[widx] <= cmd_q.key;
    rdata_q <= keys[cnt_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            cmd_q     <= cmd_i;
            cnt_q     <= '0;
            cmp_vld_q <= 1'b0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_q <= (cnt_q < CNT_W'(TABLE_ENTRIES));
          cmp_idx_q <= cnt_q[IDX_W-1:0];
          if (cnt_q < CNT_W'(TABLE_ENTRIES)) cnt_q <= cnt_q + CNT_W'(1);
          if (cmp_vld_q) begin
            if (valid_q[cmp_idx_q] && rdata_q == cmd_q.key && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= cmp_idx_q;
            end
            if (!valid_q[cmp_idx_q] && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
          end else if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            case (cmd_q.cmd)
              CMD_LOOKUP: begin
                kind_q    <= KIND_VERDICT;
                verdict_q <= cmd_q.hdr_done && hit_q && drop_q[hit_idx_q];
                status_q  <= ST_OK;
              end
              CMD_SET: begin
                kind_q    <= KIND_ACK;
                verdict_q <= 1'b0;
                if (hit_q || free_q) begin
                  valid_q[widx] <= 1'b1;
                  drop_q[widx]  <= cmd_q.drop;
                  status_q      <= ST_OK;
                end else begin
                  status_q <= ST_FULL;
                end
              end
              default: begin
                kind_q    <= KIND_ACK;
                verdict_q <= 1'b0;
                if (hit_q) begin
                  valid_q[hit_idx_q] <= 1'b0;
                  drop_q[hit_idx_q]  <= 1'b0;
                  status_q           <= ST_OK;
                end else begin
                  status_q <= ST_NOTFOUND;
                end
              end
            endcase
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(status_q) && $stable(verdict_q))
    else $error("result word dropped under stall");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("scan counter overran");
  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_ACK |-> !verdict_q)
    else $error("ack with drop verdict");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_SCAN)
    else $error("popped command not scanned");

endmodule

FILE: hw/rtl/ipv4_source_blocklist_filter.sv
// Top level of the IPv4 source blocklist filter.
//   channel | direction | handshake          | fields
//   in      | input     | in_valid_i/in_stall_o   | op, data_byte, last_byte, key_address, entry_value
//   out     | output    | out_valid_o/out_stall_i | kind, verdict, status
// A frame byte that is not last only advances the parser. A last byte or table
// word queues a command; the table engine scans all TABLE_ENTRIES keys in the
// key memory (one per cycle) for each queued command.
// Reset clears all table valid bits at once; no clearing pass is needed.
// Input stalls only while the two-entry command queue is full.
module ipv4_source_blocklist_filter import bsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] key_address_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        verdict_o,
  output logic [1:0]  status_o
);

  logic accept, push, full, pop, avail;
  cmd_t f_cmd, q_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bsf_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .op_i, .data_byte_i, .last_byte_i,
    .key_address_i, .entry_value_i, .push_o(push), .cmd_o(f_cmd)
  );

  bsf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(f_cmd), .full_o(full),
    .pop_i(pop), .avail_o(avail), .cmd_o(q_cmd)
  );

  bsf_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .cmd_i(q_cmd), .pop_o(pop),
    .out_valid_o, .out_stall_i, .kind_o, .verdict_o, .status_o
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the IPv4 source blocklist filter.
module tb;
  import bsf_pkg::*;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_QINQ = 16'h88A8;

  typedef enum logic [2:0] {
    PH_ETH, PH_TAG, PH_IPV4, PH_DONE, PH_PASS
  } phase_e;

  typedef struct packed {
    logic    kind;
    logic    verdict;
    logic [1:0] status;
  } verdict_t;

  typedef struct {
    op_e         op;
    logic [7:0]  data;
    logic        last;
    logic [31:0] key;
    logic [31:0] value;
    logic        typed;
    verdict_t    res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [31:0] key_address_i = '0;
  logic [31:0] entry_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic        verdict_o;
  logic [1:0]  status_o;

  ipv4_source_blocklist_filter u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // filter model state
  logic [31:0] blk_key [TABLE_ENTRIES];
  logic        blk_drop [TABLE_ENTRIES];
  logic        blk_valid [TABLE_ENTRIES];
  logic [5:0]  offs, hdr_start;
  logic [15:0] eth_type;
  logic [1:0]  n_tags;
  phase_e      phase;
  logic [31:0] src_addr;

  verdict_t    verdicts_q [$];
  int          errors = 0;
  bit          quiet = 0;
  logic [31:0] key_pool [16];

  task automatic frame_reset();
    offs = '0; hdr_start = '0; eth_type = '0; n_tags = '0;
    phase = PH_ETH; src_addr = '0;
  endtask

  function automatic int lookup(logic [31:0] k);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (blk_valid[i] && blk_key[i] == k) return i;
    return -1;
  endfunction

  task automatic pick_phase(logic [5:0] nxt, bit may_tag);
    if (may_tag && (eth_type == ETH_VLAN || eth_type == ETH_QINQ)) begin
      phase = PH_TAG; hdr_start = nxt;
    end else if (eth_type == ETH_IPV4) begin
      phase = PH_IPV4; hdr_start = nxt;
    end else begin
      phase = PH_PASS;
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    logic [5:0] rel;
    rel = offs - hdr_start;
    case (phase)
      PH_ETH: begin
        if (offs == 12) eth_type = {b, 8'h00};
        else if (offs == 13) begin
          eth_type[7:0] = b;
          pick_phase(6'd14, 1'b1);
        end
      end
      PH_TAG: begin
        if (rel == 2) eth_type = {b, 8'h00};
        else if (rel == 3) begin
          eth_type[7:0] = b;
          n_tags = n_tags + 2'd1;
          pick_phase(offs + 6'd1, n_tags < 2'd2);
        end
      end
      PH_IPV4: begin
        if (rel >= 12 && rel <= 15) src_addr = {src_addr[23:0], b};
        if (rel == 19) phase = PH_DONE;
      end
      default: ;
    endcase
    if (offs < 6'd63) offs = offs + 6'd1;
  endtask

  // Returns 1 and the result when the word produces one.
  task automatic filter_word(input op_e op, input logic [7:0] b, input logic last,
                             input logic [31:0] k, input logic [31:0] v,
                             output bit has, output verdict_t r);
    int idx;
    has = 0;
    r = '0;
    case (op)
      OP_FRAME: begin
        parse_byte(b);
        if (last) begin
          if (phase == PH_DONE) begin
            idx = lookup(src_addr);
            if (idx >= 0 && blk_drop[idx]) r.verdict = 1'b1;
          end
          frame_reset();
          r.kind = KIND_VERDICT;
          has = 1;
        end
      end
      OP_SET: begin
        idx = lookup(k);
        if (idx < 0)
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!blk_valid[i]) begin idx = i; break; end
        if (idx < 0) r.status = ST_FULL;
        else begin
          blk_valid[idx] = 1'b1; blk_key[idx] = k; blk_drop[idx] = (v != 0);
        end
        r.kind = KIND_ACK;
        has = 1;
      end
      OP_DEL: begin
        idx = lookup(k);
        if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          blk_valid[idx] = 1'b0; blk_drop[idx] = 1'b0;
        end
        r.kind = KIND_ACK;
        has = 1;
      end
      default: ;
    endcase
  endtask

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < 20);
  endfunction

  // Drives one word at the falling edge and waits for it to be taken.
  task automatic send_word(op_e op, logic [7:0] b, logic last, logic [31:0] k,
                           logic [31:0] v, bit typed = 0, verdict_t tr = '0);
    bit has;
    verdict_t r;
    while (idle_roll()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op; data_byte_i = b; last_byte_i = last;
    key_address_i = k; entry_value_i = v;
    do @(posedge clk_i); while (in_stall_o);
    filter_word(op, b, last, k, v, has, r);
    if (has) verdicts_q.push_back(typed ? tr : r);
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    send_word(OP_FRAME, b, last, $urandom, $urandom);
  endtask

  // One frame; mostly well-formed IPv4 with random tagging and length.
  task automatic send_frame();
    logic [7:0] fb [64];
    int ntag, len, full, sel, p;
    logic [31:0] src;
    logic [15:0] tt;
    for (int i = 0; i < 64; i++) fb[i] = 8'($urandom);
    sel = $urandom_range(99);
    ntag = (sel < 10) ? 3 : $urandom_range(2);
    p = 12;
    for (int t = 0; t < ntag; t++) begin
      tt = $urandom_range(1) ? ETH_VLAN : ETH_QINQ;
      {fb[p], fb[p+1]} = tt;
      p += 4;
    end
    tt = (sel >= 10 && sel < 20) ? 16'($urandom) : ETH_IPV4;
    {fb[p], fb[p+1]} = tt;
    p += 2;
    src = $urandom_range(3) != 0 ? key_pool[$urandom_range(15)] : $urandom;
    {fb[p+12], fb[p+13], fb[p+14], fb[p+15]} = src;
    full = p + 20;
    if (sel >= 20 && sel < 30) len = $urandom_range(full - 1, 1);
    else if (sel >= 30 && sel < 35) len = $urandom_range(100, 70);
    else len = full + $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3)
        send_word(op_e'($urandom_range(2, 1)), 8'($urandom), 1'($urandom),
                  key_pool[$urandom_range(15)], $urandom_range(1) ? $urandom : 0);
      send_byte(fb[i % 64], i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_q.size() == 0) begin
        $error("unexpected word kind=%0d verdict=%0d status=%0d",
               kind_o, verdict_o, status_o);
        errors++;
      end else begin
        e = verdicts_q.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o); errors++;
        end
        if (verdict_o !== e.verdict) begin
          $error("verdict: expected %0d, got %0d", e.verdict, verdict_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o); errors++;
        end
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= idle_roll();

  initial begin
    #(12 * 1500000);
    $display("tb failed");
    $finish;
  end

  initial begin
    row_t rows [$];
    logic [31:0] fill_keys [TABLE_ENTRIES];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      blk_valid[i] = 1'b0; blk_drop[i] = 1'b0; blk_key[i] = '0;
    end
    frame_reset();
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    rows = '{
      '{OP_DEL,   8'h00, 1'b0, 32'h0000_0000, 32'h0, 1, '{KIND_ACK, 1'b0, ST_NOTFOUND}},
      '{OP_SET,   8'h00, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{KIND_ACK, 1'b0, ST_OK}},
      '{OP_SET,   8'hFF, 1'b1, 32'h0000_0000, 32'h0, 1, '{KIND_ACK, 1'b0, ST_OK}},
      '{OP_SET,   8'h00, 1'b0, 32'h0000_0000, 32'h1, 1, '{KIND_ACK, 1'b0, ST_OK}},
      '{OP_NONE,  8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
      '{OP_FRAME, 8'hFF, 1'b1, 32'h0, 32'h0, 1, '{KIND_VERDICT, 1'b0, ST_OK}},
      '{OP_FRAME, 8'h00, 1'b0, 32'h0, 32'h0, 0, '0},
      '{OP_FRAME, 8'h00, 1'b1, 32'h0, 32'h0, 1, '{KIND_VERDICT, 1'b0, ST_OK}},
      '{OP_DEL,   8'h00, 1'b0, 32'h0000_0000, 32'h0, 1, '{KIND_ACK, 1'b0, ST_OK}},
      '{OP_DEL,   8'h00, 1'b0, 32'h0000_0000, 32'h0, 1, '{KIND_ACK, 1'b0, ST_NOTFOUND}},
      '{OP_SET,   8'h00, 1'b0, 32'h0000_0000, 32'h8000_0000, 0, '0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_word(rows[i].op, rows[i].data, rows[i].last, rows[i].key, rows[i].value,
                rows[i].typed, rows[i].res);

    // blocked IPv4 source, untagged, single tag and double tag
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < 12; i++) send_byte(8'($urandom), 1'b0);
      if (t > 0) for (int j = 0; j < t; j++) begin
        send_byte(8'h81, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'($urandom), 1'b0); send_byte(8'($urandom), 1'b0);
      end
      send_byte(8'h08, 1'b0); send_byte(8'h00, 1'b0);
      for (int i = 0; i < 20; i++)
        send_byte((i >= 12 && i <= 15) ? 8'hFF : 8'($urandom), i == 19);
    end

    for (int n = 0; n < 10; n++) begin
      quiet = (n >= 3 && n < 7);
      if ($urandom_range(99) < 15)
        send_word(op_e'($urandom_range(3)), 8'($urandom), 1'($urandom),
                  $urandom_range(4) ? key_pool[$urandom_range(15)] : $urandom,
                  $urandom_range(2) ? $urandom : 0);
      else if ($urandom_range(99) < 5)
        send_byte(8'($urandom), 1'b1);
      else
        send_frame();
    end
    quiet = 0;

    // fill the table to overflow, then free part of it again
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      fill_keys[i] = $urandom;
      send_word(OP_SET, 8'($urandom), 1'($urandom), fill_keys[i], $urandom);
    end
    send_word(OP_SET, 8'h00, 1'b0, 32'h1234_5678, 32'h1);
    send_frame();
    for (int i = 0; i < 32; i++)
      send_word(OP_DEL, 8'($urandom), 1'($urandom), fill_keys[i], $urandom);

    for (int n = 0; n < 4; n++) begin
      if ($urandom_range(99) < 25)
        send_word(op_e'($urandom_range(2, 1)), 8'($urandom), 1'($urandom),
                  key_pool[$urandom_range(15)], $urandom_range(1) ? $urandom : 0);
      else
        send_frame();
    end

    in_valid_i = 1'b0;
    while (verdicts_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
